// ----- src/stvk_pkg.sv -----
// Shared constants and saturation helper for the St. Venant-Kirchhoff stress core.
// No dependencies.
`default_nettype none
package stvk_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DIM            = 3;
    localparam int WIDE_W         = 128;
    localparam int NORM_W         = 64;
    localparam int HALF_W         = 32;

    typedef enum logic [0:0] {
        REG_SHEAR  = 1'b0,
        REG_LAMBDA = 1'b1
    } reg_idx_t;

    // Clamp a wide signed value to the signed range of w bits.
    function automatic logic signed [WIDE_W-1:0] sat_to(
        input logic signed [WIDE_W-1:0] x,
        input int                       w
    );
        logic signed [WIDE_W-1:0] maxv;
        logic signed [WIDE_W-1:0] minv;
        maxv = (WIDE_W'(1) <<< (w - 1)) - WIDE_W'(1);
        minv = -maxv - WIDE_W'(1);
        if (x > maxv)
            return maxv;
        else if (x < minv)
            return minv;
        else
            return x;
    endfunction

endpackage
`default_nettype wire

// ----- src/stvk_stress_and_energy_core.sv -----
// St. Venant-Kirchhoff first Piola-Kirchhoff stress and strain energy, top level.
// Depends on stvk_pkg, stvk_gram, stvk_stress, stvk_out.
//
// Usage:
//   Present a deformation gradient F (nine signed Q16.16 entries, row-major) on
//   f_r0c0..f_r2c2 and raise start. busy stays low, so a transfer happens at
//   every edge with start high; one item may enter each clock.
//   done rises and the result is taken as the item leaves the last register
//   stage, with P = F S on p_r0c0..p_r2c2 and the energy density on
//   strain_energy (Q32.16). All results are clamped to their field range.
//   Throughput is one item per clock; the pipeline has six register stages: two for
//   the Green strain, two for S and the energy norms, two for P and the energy.
//   Lame mu and lambda are written on cfg_we/cfg_index/cfg_data and are taken
//   to be steady while items are in flight; unknown indices are ignored.
//   Reset clears the pipeline valid bits and sets both moduli to 1.0.
//   There is no back-pressure: the receiver must take done when it appears.
`default_nettype none
module stvk_stress_and_energy_core
    import stvk_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [WORD_WIDTH-1:0]             cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r0c0,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r0c1,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r0c2,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r1c0,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r1c1,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r1c2,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r2c0,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r2c1,
    input  wire logic signed [WORD_WIDTH-1:0]      f_r2c2,
    output logic                                   done,
    output logic signed [WORD_WIDTH-1:0]           p_r0c0,
    output logic signed [WORD_WIDTH-1:0]           p_r0c1,
    output logic signed [WORD_WIDTH-1:0]           p_r0c2,
    output logic signed [WORD_WIDTH-1:0]           p_r1c0,
    output logic signed [WORD_WIDTH-1:0]           p_r1c1,
    output logic signed [WORD_WIDTH-1:0]           p_r1c2,
    output logic signed [WORD_WIDTH-1:0]           p_r2c0,
    output logic signed [WORD_WIDTH-1:0]           p_r2c1,
    output logic signed [WORD_WIDTH-1:0]           p_r2c2,
    output logic signed [WORD_WIDTH+FRAC_BITS-1:0] strain_energy
);
    localparam logic [WORD_WIDTH-1:0] RESET_ONE = WORD_WIDTH'(1) << FRAC_BITS;

    logic signed [WORD_WIDTH-1:0] mu_reg;
    logic signed [WORD_WIDTH-1:0] lam_reg;
    logic                         in_valid;
    logic signed [WORD_WIDTH-1:0] f_arr [DIM][DIM];
    logic                         e_valid;
    logic signed [WORD_WIDTH-1:0] e_arr [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] f_e   [DIM][DIM];
    logic                         s_valid;
    logic signed [WORD_WIDTH-1:0] s_arr [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] f_s   [DIM][DIM];
    logic signed [NORM_W-1:0]     n_val;
    logic signed [NORM_W-1:0]     q_val;
    logic signed [WORD_WIDTH-1:0] p_arr [DIM][DIM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg  <= RESET_ONE;
            lam_reg <= RESET_ONE;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SHEAR:  mu_reg  <= cfg_data;
                REG_LAMBDA: lam_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    assign f_arr[0][0] = f_r0c0;
    assign f_arr[0][1] = f_r0c1;
    assign f_arr[0][2] = f_r0c2;
    assign f_arr[1][0] = f_r1c0;
    assign f_arr[1][1] = f_r1c1;
    assign f_arr[1][2] = f_r1c2;
    assign f_arr[2][0] = f_r2c0;
    assign f_arr[2][1] = f_r2c1;
    assign f_arr[2][2] = f_r2c2;

    stvk_gram #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_gram (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .f_in     (f_arr),
        .e_valid  (e_valid),
        .e_out    (e_arr),
        .f_out    (f_e)
    );

    stvk_stress #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_stress (
        .clk     (clk),
        .rst_n   (rst_n),
        .e_valid (e_valid),
        .e_in    (e_arr),
        .f_in    (f_e),
        .mu      (mu_reg),
        .lam     (lam_reg),
        .s_valid (s_valid),
        .s_out   (s_arr),
        .f_out   (f_s),
        .n_out   (n_val),
        .q_out   (q_val)
    );

    stvk_out #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_valid),
        .s_in    (s_arr),
        .f_in    (f_s),
        .n_in    (n_val),
        .q_in    (q_val),
        .mu      (mu_reg),
        .lam     (lam_reg),
        .done    (done),
        .p_out   (p_arr),
        .energy  (strain_energy)
    );

    assign p_r0c0 = p_arr[0][0];
    assign p_r0c1 = p_arr[0][1];
    assign p_r0c2 = p_arr[0][2];
    assign p_r1c0 = p_arr[1][0];
    assign p_r1c1 = p_arr[1][1];
    assign p_r1c2 = p_arr[1][2];
    assign p_r2c0 = p_arr[2][0];
    assign p_r2c1 = p_arr[2][1];
    assign p_r2c2 = p_arr[2][2];

endmodule
`default_nettype wire

// ----- src/stvk_gram.sv -----
// Green strain stage pair: products of F^T F, then sum, shift and clamp to E.
// Depends on stvk_pkg.
`default_nettype none
module stvk_gram
    import stvk_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic signed [WORD_WIDTH-1:0] f_in  [DIM][DIM],
    output logic                              e_valid,
    output logic signed [WORD_WIDTH-1:0]      e_out [DIM][DIM],
    output logic signed [WORD_WIDTH-1:0]      f_out [DIM][DIM]
);
    localparam int PW = 2 * WORD_WIDTH;

    logic                         v1_reg;
    logic                         v2_reg;
    logic signed [PW-1:0]         prod_reg [DIM][DIM][DIM];
    logic signed [WORD_WIDTH-1:0] f1_reg   [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] f2_reg   [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] e_reg    [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] e_next   [DIM][DIM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    for (genvar i = 0; i < DIM; i++)
    begin : g_row
        for (genvar j = 0; j < DIM; j++)
        begin : g_col
            logic signed [WIDE_W-1:0] acc;
            for (genvar k = 0; k < DIM; k++)
            begin : g_k
                always_ff @(posedge clk)
                begin
                    prod_reg[i][j][k] <= f_in[k][i] * f_in[k][j];
                end
            end

            always_comb
            begin
                acc = WIDE_W'(prod_reg[i][j][0]) + WIDE_W'(prod_reg[i][j][1])
                    + WIDE_W'(prod_reg[i][j][2]);
                if (i == j)
                    acc = acc - (WIDE_W'(1) <<< (2 * FRAC_BITS));
                e_next[i][j] = WORD_WIDTH'(sat_to(acc >>> (FRAC_BITS + 1), WORD_WIDTH));
            end

            always_ff @(posedge clk)
            begin
                f1_reg[i][j] <= f_in[i][j];
                f2_reg[i][j] <= f1_reg[i][j];
                e_reg[i][j]  <= e_next[i][j];
            end
        end
    end

    assign e_valid = v2_reg;
    assign e_out   = e_reg;
    assign f_out   = f2_reg;

endmodule
`default_nettype wire

// ----- src/stvk_stress.sv -----
// Second Piola-Kirchhoff stress and energy norms: moduli products, then S, |E|^2, tr^2.
// Depends on stvk_pkg.
`default_nettype none
module stvk_stress
    import stvk_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         e_valid,
    input  wire logic signed [WORD_WIDTH-1:0] e_in  [DIM][DIM],
    input  wire logic signed [WORD_WIDTH-1:0] f_in  [DIM][DIM],
    input  wire logic signed [WORD_WIDTH-1:0] mu,
    input  wire logic signed [WORD_WIDTH-1:0] lam,
    output logic                              s_valid,
    output logic signed [WORD_WIDTH-1:0]      s_out [DIM][DIM],
    output logic signed [WORD_WIDTH-1:0]      f_out [DIM][DIM],
    output logic signed [NORM_W-1:0]          n_out,
    output logic signed [NORM_W-1:0]          q_out
);
    localparam int TW = WORD_WIDTH + 2;
    localparam int PW = 2 * WORD_WIDTH;

    logic                         v3_reg;
    logic                         v4_reg;
    logic signed [TW-1:0]         tr;
    logic signed [PW-1:0]         me_reg  [DIM][DIM];
    logic signed [PW-1:0]         esq_reg [DIM][DIM];
    logic signed [PW+1:0]         lt_reg;
    logic signed [2*TW-1:0]       tsq_reg;
    logic signed [WORD_WIDTH-1:0] f3_reg  [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] f4_reg  [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] s_reg   [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] s_next  [DIM][DIM];
    logic signed [NORM_W-1:0]     n_reg;
    logic signed [NORM_W-1:0]     n_next;
    logic signed [NORM_W-1:0]     q_reg;
    logic signed [NORM_W-1:0]     q_next;
    logic signed [WIDE_W-1:0]     nsum;

    assign tr = TW'(e_in[0][0]) + TW'(e_in[1][1]) + TW'(e_in[2][2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= e_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lt_reg  <= lam * tr;
        tsq_reg <= tr * tr;
        n_reg   <= n_next;
        q_reg   <= q_next;
    end

    always_comb
    begin
        nsum = '0;
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
                nsum = nsum + WIDE_W'(esq_reg[i][j]);
        n_next = NORM_W'(sat_to(nsum >>> FRAC_BITS, NORM_W));
        q_next = NORM_W'(sat_to(WIDE_W'(tsq_reg) >>> FRAC_BITS, NORM_W));
    end

    for (genvar i = 0; i < DIM; i++)
    begin : g_row
        for (genvar j = 0; j < DIM; j++)
        begin : g_col
            logic signed [WIDE_W-1:0] acc;

            always_comb
            begin
                acc = WIDE_W'(me_reg[i][j]) <<< 1;
                if (i == j)
                    acc = acc + WIDE_W'(lt_reg);
                s_next[i][j] = WORD_WIDTH'(sat_to(acc >>> FRAC_BITS, WORD_WIDTH));
            end

            always_ff @(posedge clk)
            begin
                me_reg[i][j]  <= mu * e_in[i][j];
                esq_reg[i][j] <= e_in[i][j] * e_in[i][j];
                f3_reg[i][j]  <= f_in[i][j];
                f4_reg[i][j]  <= f3_reg[i][j];
                s_reg[i][j]   <= s_next[i][j];
            end
        end
    end

    assign s_valid = v4_reg;
    assign s_out   = s_reg;
    assign f_out   = f4_reg;
    assign n_out   = n_reg;
    assign q_out   = q_reg;

endmodule
`default_nettype wire

// ----- src/stvk_out.sv -----
// Output stage pair: P = F S products and split energy products, then sums and clamps.
// Depends on stvk_pkg.
`default_nettype none
module stvk_out
    import stvk_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_valid,
    input  wire logic signed [WORD_WIDTH-1:0]          s_in [DIM][DIM],
    input  wire logic signed [WORD_WIDTH-1:0]          f_in [DIM][DIM],
    input  wire logic signed [NORM_W-1:0]              n_in,
    input  wire logic signed [NORM_W-1:0]              q_in,
    input  wire logic signed [WORD_WIDTH-1:0]          mu,
    input  wire logic signed [WORD_WIDTH-1:0]          lam,
    output logic                                       done,
    output logic signed [WORD_WIDTH-1:0]               p_out [DIM][DIM],
    output logic signed [WORD_WIDTH+FRAC_BITS-1:0]     energy
);
    localparam int PW = 2 * WORD_WIDTH;
    localparam int EW = WORD_WIDTH + FRAC_BITS;
    localparam int LW = WORD_WIDTH + HALF_W + 1;

    logic                         v5_reg;
    logic                         v6_reg;
    logic signed [PW-1:0]         pp_reg   [DIM][DIM][DIM];
    logic signed [WORD_WIDTH-1:0] p_reg    [DIM][DIM];
    logic signed [WORD_WIDTH-1:0] p_next   [DIM][DIM];
    logic signed [LW-1:0]         mun_lo_reg;
    logic signed [LW-1:0]         mun_hi_reg;
    logic signed [LW-1:0]         lq_lo_reg;
    logic signed [LW-1:0]         lq_hi_reg;
    logic signed [WIDE_W-1:0]     eacc;
    logic signed [EW-1:0]         energy_reg;
    logic signed [EW-1:0]         energy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= s_valid;
            v6_reg <= v5_reg;
        end
    end

    // 64-bit norms are split into halves; low half taken unsigned
    always_ff @(posedge clk)
    begin
        mun_lo_reg <= mu  * $signed({1'b0, n_in[HALF_W-1:0]});
        mun_hi_reg <= mu  * $signed(n_in[NORM_W-1:HALF_W]);
        lq_lo_reg  <= lam * $signed({1'b0, q_in[HALF_W-1:0]});
        lq_hi_reg  <= lam * $signed(q_in[NORM_W-1:HALF_W]);
        energy_reg <= energy_next;
    end

    always_comb
    begin
        eacc = ((WIDE_W'(mun_hi_reg) <<< HALF_W) + WIDE_W'(mun_lo_reg)) <<< 1;
        eacc = eacc + (WIDE_W'(lq_hi_reg) <<< HALF_W) + WIDE_W'(lq_lo_reg);
        energy_next = EW'(sat_to(eacc >>> (FRAC_BITS + 1), EW));
    end

    for (genvar i = 0; i < DIM; i++)
    begin : g_row
        for (genvar j = 0; j < DIM; j++)
        begin : g_col
            logic signed [WIDE_W-1:0] acc;
            for (genvar k = 0; k < DIM; k++)
            begin : g_k
                always_ff @(posedge clk)
                begin
                    pp_reg[i][j][k] <= f_in[i][k] * s_in[k][j];
                end
            end

            always_comb
            begin
                acc = WIDE_W'(pp_reg[i][j][0]) + WIDE_W'(pp_reg[i][j][1])
                    + WIDE_W'(pp_reg[i][j][2]);
                p_next[i][j] = WORD_WIDTH'(sat_to(acc >>> FRAC_BITS, WORD_WIDTH));
            end

            always_ff @(posedge clk)
            begin
                p_reg[i][j] <= p_next[i][j];
            end
        end
    end

    assign done   = v6_reg;
    assign p_out  = p_reg;
    assign energy = energy_reg;

endmodule
`default_nettype wire
